[rtl/ret_pkg.sv]
// ----------------------------------------------------------------------------
// ret_pkg
// Types and codes shared by the rumble effect table and its slot update logic.
// ----------------------------------------------------------------------------
package ret_pkg;

  // request modes
  typedef enum logic [1:0] {
    MODE_UPLOAD = 2'd0,
    MODE_ERASE  = 2'd1,
    MODE_PLAY   = 2'd2,
    MODE_TICK   = 2'd3
  } mode_t;

  // result status codes
  localparam logic [1:0] STATUS_OK           = 2'd0;
  localparam logic [1:0] STATUS_INVALID      = 2'd1;
  localparam logic [1:0] STATUS_PLAY_IGNORED = 2'd2;

  // one stored effect slot
  typedef struct packed {
    logic        valid;
    logic [15:0] strong_mag;
    logic [15:0] weak_mag;
    logic [15:0] length;
    logic [15:0] delay;
    logic        playing;
    logic [15:0] delay_left;
    logic [31:0] run_left;
    logic        endless;
  } slot_t;

  // latched request, applied to every slot during a pass
  typedef struct packed {
    mode_t       mode;
    logic        is_rumble;
    logic [15:0] strong_mag;
    logic [15:0] weak_mag;
    logic [15:0] length;
    logic [15:0] delay;
    logic [15:0] count;
  } cmd_t;

endpackage

[rtl/ret_slot_update.sv]
// ----------------------------------------------------------------------------
// ret_slot_update
// Applies one request to one slot record, then expires a finished effect
// and reports whether the slot drives the motors.
// ----------------------------------------------------------------------------
module ret_slot_update (
  input  ret_pkg::slot_t entry,
  input  ret_pkg::cmd_t  cmd,
  input  logic           target,
  output ret_pkg::slot_t entry_next,
  output logic           active
);

  ret_pkg::slot_t upd;
  logic [31:0]    run_total;
  logic           start;

  assign run_total = {16'd0, entry.length} * {16'd0, cmd.count};
  assign start     = entry.valid && (cmd.count != 16'd0);

  // apply the request
  always_comb begin
    upd = entry;
    case (cmd.mode)
      ret_pkg::MODE_UPLOAD: begin
        if (target && cmd.is_rumble) begin
          upd.valid      = 1'b1;
          upd.strong_mag = cmd.strong_mag;
          upd.weak_mag   = cmd.weak_mag;
          upd.length     = cmd.length;
          upd.delay      = cmd.delay;
        end
      end
      ret_pkg::MODE_ERASE: begin
        if (target) begin
          upd = '0;
        end
      end
      ret_pkg::MODE_PLAY: begin
        if (target) begin
          upd.playing = start;
          if (start) begin
            upd.delay_left = entry.delay;
            upd.endless    = (entry.length == 16'd0);
            upd.run_left   = run_total;
          end
        end
      end
      ret_pkg::MODE_TICK: begin
        if (entry.playing) begin
          if (entry.delay_left != 16'd0) begin
            upd.delay_left = entry.delay_left - 16'd1;
          end else if (!entry.endless && entry.run_left != 32'd0) begin
            upd.run_left = entry.run_left - 32'd1;
          end
        end
      end
      default: begin
        upd = entry;
      end
    endcase
  end

  // drop an effect whose time is up, then form the activity flag
  always_comb begin
    entry_next = upd;
    if (upd.playing && !upd.endless && upd.delay_left == 16'd0 &&
        upd.run_left == 32'd0) begin
      entry_next.playing = 1'b0;
    end
    active = entry_next.playing && (entry_next.delay_left == 16'd0) &&
             ((entry_next.strong_mag != 16'd0) || (entry_next.weak_mag != 16'd0));
  end

endmodule

[rtl/rumble_effect_table.sv]
// ----------------------------------------------------------------------------
// rumble_effect_table
// Table of rumble effects kept in one slot memory, updated by a read-modify-
// write sweep over every slot for each request.
// ----------------------------------------------------------------------------
// Sweep: a read state, then a modify state that handles one slot per cycle
// through the single read and write port of the memory, then a done state.
// No new request is taken until the done state has passed the result out.
// Reset: synchronous; the per-slot live bits clear at once so every slot
// reads as empty; no clearing pass is needed and the block is ready at once.
module rumble_effect_table #(
  parameter int EFFECT_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [15:0] slot_id,
  input  logic        is_rumble,
  input  logic [15:0] strong_level,
  input  logic [15:0] weak_level,
  input  logic [15:0] length_ms,
  input  logic [15:0] delay_ms,
  input  logic [15:0] play_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic        rumble_active
);

  localparam int IDXW = (EFFECT_SLOTS > 1) ? $clog2(EFFECT_SLOTS) : 1;
  localparam int SLOTW = $bits(ret_pkg::slot_t);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_MOD  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t            state;
  state_t            state_next;
  ret_pkg::cmd_t     cmd;
  logic [15:0]       cmd_id;
  logic              cmd_in_range;
  logic [1:0]        pass_status;
  logic              pass_active;
  logic [IDXW-1:0]   idx;
  logic [IDXW-1:0]   raddr;
  logic              last;
  logic              accept;
  logic              out_free;
  logic              in_range;

  logic [SLOTW-1:0]        mem [EFFECT_SLOTS];
  logic [EFFECT_SLOTS-1:0] live;
  logic [SLOTW-1:0]        rdata;
  logic                    rd_live;
  ret_pkg::slot_t          entry;
  ret_pkg::slot_t          entry_next;
  logic                    slot_active;
  logic                    target;
  logic                    we;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_range = (slot_id < 16'(EFFECT_SLOTS));
  assign last     = (idx == IDXW'(EFFECT_SLOTS - 1));
  assign raddr    = (state == ST_READ) ? idx : idx + IDXW'(1);
  assign we       = (state == ST_MOD);
  assign target   = cmd_in_range && (cmd_id[IDXW-1:0] == idx);
  assign entry    = rd_live ? ret_pkg::slot_t'(rdata) : '0;

  // slot memory: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[idx] <= SLOTW'(entry_next);
    end
    rdata <= mem[raddr];
  end

  // live bits: a slot never written since reset reads as empty
  always_ff @(posedge clk) begin
    if (rst) begin
      live    <= '0;
      rd_live <= 1'b0;
    end else begin
      if (we) begin
        live[idx] <= 1'b1;
      end
      rd_live <= live[raddr];
    end
  end

  ret_slot_update u_slot (
    .entry      (entry),
    .cmd        (cmd),
    .target     (target),
    .entry_next (entry_next),
    .active     (slot_active)
  );

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_MOD;
      end
      ST_MOD: begin
        if (last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // latch the request and its status
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd.mode       <= ret_pkg::mode_t'(mode);
      cmd.is_rumble  <= is_rumble;
      cmd.strong_mag <= strong_level;
      cmd.weak_mag   <= weak_level;
      cmd.length     <= length_ms;
      cmd.delay      <= delay_ms;
      cmd.count      <= play_count;
      cmd_id         <= slot_id;
      cmd_in_range   <= in_range;
      case (ret_pkg::mode_t'(mode))
        ret_pkg::MODE_UPLOAD: begin
          pass_status <= (!is_rumble || !in_range) ? ret_pkg::STATUS_INVALID
                                                   : ret_pkg::STATUS_OK;
        end
        ret_pkg::MODE_ERASE: begin
          pass_status <= in_range ? ret_pkg::STATUS_OK : ret_pkg::STATUS_INVALID;
        end
        ret_pkg::MODE_PLAY: begin
          pass_status <= in_range ? ret_pkg::STATUS_OK
                                  : ret_pkg::STATUS_PLAY_IGNORED;
        end
        default: begin
          pass_status <= ret_pkg::STATUS_OK;
        end
      endcase
    end
  end

  // advance the slot index and gather activity over the sweep
  always_ff @(posedge clk) begin
    if (accept) begin
      idx         <= '0;
      pass_active <= 1'b0;
    end else if (state == ST_MOD) begin
      pass_active <= pass_active | slot_active;
      if (!last) begin
        idx <= idx + IDXW'(1);
      end
    end
  end

  // output register: hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      status        <= pass_status;
      rumble_active <= pass_active;
    end
  end

endmodule

[verif/rumble_effect_table_tb.sv]
// ----------------------------------------------------------------------------
// rumble_effect_table_tb
// Self-checking bench for the rumble effect table. A cycle-free predictor
// keeps its own copy of every effect slot and works out the status and the
// rumble-active flag for each accepted request. The checker compares them
// with the block's results in order. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module rumble_effect_table_tb;

  localparam int EFFECT_SLOTS   = 16;
  localparam int CLK_PERIOD     = 20;
  localparam int TIMEOUT_CYCLES = 1_000_000;
  localparam int DRAIN_CYCLES   = 2 * EFFECT_SLOTS + 8;
  localparam int MAX_PRINTED    = 40;

  // one request as offered to the block
  typedef struct packed {
    ret_pkg::mode_t op;
    logic [15:0]    slot;
    logic           rumble;
    logic [15:0]    strong_mag;
    logic [15:0]    weak_mag;
    logic [15:0]    len;
    logic [15:0]    dly;
    logic [15:0]    count;
  } request_t;

  // one result as returned by the block
  typedef struct packed {
    logic [1:0] status;
    logic       active;
  } outcome_t;

  // predicted contents of one effect slot
  typedef struct packed {
    logic        stored;
    logic [15:0] strong_mag;
    logic [15:0] weak_mag;
    logic [15:0] len;
    logic [15:0] dly;
    logic        playing;
    logic [15:0] ms_to_start;
    logic [31:0] ms_to_run;
    logic        endless;
  } effect_t;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic [1:0]  mode          = '0;
  logic [15:0] slot_id       = '0;
  logic        is_rumble     = 1'b0;
  logic [15:0] strong_level  = '0;
  logic [15:0] weak_level    = '0;
  logic [15:0] length_ms     = '0;
  logic [15:0] delay_ms      = '0;
  logic [15:0] play_count    = '0;
  logic        out_valid;
  logic        out_stall     = 1'b0;
  logic [1:0]  status;
  logic        rumble_active;

  effect_t  effects [EFFECT_SLOTS];
  outcome_t pending_outcomes [$];
  int       errors   = 0;
  int       hold_len = 0;
  bit       idle_on  = 1'b1;

  rumble_effect_table #(
    .EFFECT_SLOTS(EFFECT_SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .slot_id(slot_id),
    .is_rumble(is_rumble),
    .strong_level(strong_level),
    .weak_level(weak_level),
    .length_ms(length_ms),
    .delay_ms(delay_ms),
    .play_count(play_count),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .rumble_active(rumble_active)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // print one mismatch line, keep counting once the print budget is spent
  task automatic report_mismatch(input string what);
    if (errors < MAX_PRINTED) begin
      $display("MISMATCH at %0t: %s", $time, what);
    end
    errors++;
  endtask

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 4);
    if (roll < 95) return $urandom_range(5, 20);
    return $urandom_range(30, 60);
  endfunction

  // apply one request to the predicted slots and form its result
  function automatic outcome_t predict_outcome(input request_t r);
    outcome_t res;
    res.status = ret_pkg::STATUS_OK;
    res.active = 1'b0;
    case (r.op)
      ret_pkg::MODE_UPLOAD: begin
        if (!r.rumble || r.slot >= EFFECT_SLOTS) begin
          res.status = ret_pkg::STATUS_INVALID;
        end else begin
          // keep play state: a running effect carries on with its counters
          effects[r.slot].stored     = 1'b1;
          effects[r.slot].strong_mag = r.strong_mag;
          effects[r.slot].weak_mag   = r.weak_mag;
          effects[r.slot].len        = r.len;
          effects[r.slot].dly        = r.dly;
        end
      end
      ret_pkg::MODE_ERASE: begin
        if (r.slot >= EFFECT_SLOTS) res.status = ret_pkg::STATUS_INVALID;
        else effects[r.slot] = '0;
      end
      ret_pkg::MODE_PLAY: begin
        if (r.slot >= EFFECT_SLOTS) begin
          res.status = ret_pkg::STATUS_PLAY_IGNORED;
        end else begin
          effects[r.slot].playing = effects[r.slot].stored && (r.count != 0);
          if (effects[r.slot].playing) begin
            effects[r.slot].ms_to_start = effects[r.slot].dly;
            effects[r.slot].endless     = (effects[r.slot].len == 0);
            effects[r.slot].ms_to_run   = {16'd0, effects[r.slot].len} * {16'd0, r.count};
          end
        end
      end
      default: begin
        // advance every playing slot by one millisecond
        for (int s = 0; s < EFFECT_SLOTS; s++) begin
          if (effects[s].playing) begin
            if (effects[s].ms_to_start != 0)
              effects[s].ms_to_start = effects[s].ms_to_start - 16'd1;
            else if (!effects[s].endless && effects[s].ms_to_run != 0)
              effects[s].ms_to_run = effects[s].ms_to_run - 32'd1;
          end
        end
      end
    endcase
    // drop expired effects, then look for any audible one
    for (int s = 0; s < EFFECT_SLOTS; s++) begin
      if (effects[s].playing && !effects[s].endless &&
          effects[s].ms_to_start == 0 && effects[s].ms_to_run == 0)
        effects[s].playing = 1'b0;
      if (effects[s].playing && effects[s].ms_to_start == 0 &&
          (effects[s].strong_mag != 0 || effects[s].weak_mag != 0))
        res.active = 1'b1;
    end
    return res;
  endfunction

  // offer one request, hold it until taken, then idle for a random gap if idling is on
  task automatic send_request(input request_t r);
    int       gap;
    outcome_t expected;
    mode         <= r.op;
    slot_id      <= r.slot;
    is_rumble    <= r.rumble;
    strong_level <= r.strong_mag;
    weak_level   <= r.weak_mag;
    length_ms    <= r.len;
    delay_ms     <= r.dly;
    play_count   <= r.count;
    in_valid     <= 1'b1;
    do @(posedge clk); while (in_stall);
    expected = predict_outcome(r);
    pending_outcomes = {pending_outcomes, expected};
    gap = idle_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic request_t make_request(input ret_pkg::mode_t op,
                                            input logic [15:0] slot,
                                            input logic rumble,
                                            input logic [15:0] strong_mag,
                                            input logic [15:0] weak_mag,
                                            input logic [15:0] len,
                                            input logic [15:0] dly,
                                            input logic [15:0] count);
    request_t r;
    r.op         = op;
    r.slot       = slot;
    r.rumble     = rumble;
    r.strong_mag = strong_mag;
    r.weak_mag   = weak_mag;
    r.len        = len;
    r.dly        = dly;
    r.count      = count;
    return r;
  endfunction

  // mostly well-formed traffic on real slots, with some noise on top
  function automatic request_t random_request();
    request_t r;
    int roll;
    r.op         = ret_pkg::mode_t'($urandom_range(0, 3));
    r.slot       = 16'($urandom);
    r.rumble     = 1'($urandom);
    r.strong_mag = 16'($urandom);
    r.weak_mag   = 16'($urandom);
    r.len        = 16'($urandom);
    r.dly        = 16'($urandom);
    r.count      = 16'($urandom);
    if ($urandom_range(0, 99) < 8) return r;

    if ($urandom_range(0, 19) == 0) r.slot = 16'(EFFECT_SLOTS + $urandom_range(0, 3));
    else r.slot = 16'($urandom_range(0, EFFECT_SLOTS - 1));
    roll = $urandom_range(0, 99);
    if (roll < 20) begin
      r.op     = ret_pkg::MODE_UPLOAD;
      r.rumble = ($urandom_range(0, 15) != 0);
      if ($urandom_range(0, 3) == 0) r.strong_mag = '0;
      if ($urandom_range(0, 3) == 0) r.weak_mag = '0;
      if ($urandom_range(0, 19) != 0) r.len = 16'($urandom_range(0, 9));
      if ($urandom_range(0, 19) != 0) r.dly = 16'($urandom_range(0, 4));
    end else if (roll < 27) begin
      r.op = ret_pkg::MODE_ERASE;
    end else if (roll < 50) begin
      r.op = ret_pkg::MODE_PLAY;
      if ($urandom_range(0, 9) != 0) r.count = 16'($urandom_range(0, 3));
    end else begin
      r.op = ret_pkg::MODE_TICK;
    end
    return r;
  endfunction

  // extremes of upload and erase, out-of-range slots and the wrong effect type
  task automatic test_upload_checks();
    idle_on = 1'b1;
    send_request(make_request(ret_pkg::MODE_UPLOAD, 16'd0, 1'b0, 16'd5, 16'd5, 16'd1,
                              16'd0, 16'd0));
    send_request(make_request(ret_pkg::MODE_UPLOAD, 16'(EFFECT_SLOTS), 1'b1, 16'd1, 16'd1,
                              16'd1, 16'd0, 16'd0));
    send_request(make_request(ret_pkg::MODE_UPLOAD, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF,
                              16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_request(make_request(ret_pkg::MODE_UPLOAD, 16'(EFFECT_SLOTS - 1), 1'b1, 16'hFFFF,
                              16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0));
    send_request(make_request(ret_pkg::MODE_UPLOAD, 16'd0, 1'b1, 16'd0, 16'd0, 16'd0,
                              16'd0, 16'd0));
    send_request(make_request(ret_pkg::MODE_ERASE, 16'(EFFECT_SLOTS), 1'b0, '0, '0, '0,
                              '0, '0));
    send_request(make_request(ret_pkg::MODE_ERASE, 16'hFFFF, 1'b0, '0, '0, '0, '0, '0));
  endtask

  // delay, run time, expiry, stop, upload over a running effect and erase
  task automatic test_play_and_ticks();
    idle_on = 1'b1;
    send_request(make_request(ret_pkg::MODE_PLAY, 16'(EFFECT_SLOTS), 1'b0, '0, '0, '0, '0,
                              16'd1));
    send_request(make_request(ret_pkg::MODE_PLAY, 16'hFFFF, 1'b0, '0, '0, '0, '0, 16'd1));
    send_request(make_request(ret_pkg::MODE_PLAY, 16'd3, 1'b0, '0, '0, '0, '0, 16'd5));
    // two runs of two ms after a one ms delay
    send_request(make_request(ret_pkg::MODE_UPLOAD, 16'd1, 1'b1, 16'h8000, 16'd0, 16'd2,
                              16'd1, 16'd0));
    send_request(make_request(ret_pkg::MODE_PLAY, 16'd1, 1'b0, '0, '0, '0, '0, 16'd2));
    repeat (5) send_request(make_request(ret_pkg::MODE_TICK, '0, 1'b0, '0, '0, '0, '0, '0));
    // silent endless effect, then give it a magnitude while it runs
    send_request(make_request(ret_pkg::MODE_PLAY, 16'd0, 1'b0, '0, '0, '0, '0, 16'd1));
    send_request(make_request(ret_pkg::MODE_PLAY, 16'(EFFECT_SLOTS - 1), 1'b0, '0, '0, '0,
                              '0, 16'hFFFF));
    send_request(make_request(ret_pkg::MODE_UPLOAD, 16'd0, 1'b1, 16'd1, 16'd0, 16'd7,
                              16'd3, 16'd0));
    send_request(make_request(ret_pkg::MODE_PLAY, 16'd0, 1'b0, '0, '0, '0, '0, 16'd0));
    // endless weak-only effect cut short by an erase
    send_request(make_request(ret_pkg::MODE_UPLOAD, 16'd1, 1'b1, 16'd0, 16'd1, 16'd0,
                              16'd0, 16'd0));
    send_request(make_request(ret_pkg::MODE_PLAY, 16'd1, 1'b0, '0, '0, '0, '0, 16'd3));
    send_request(make_request(ret_pkg::MODE_ERASE, 16'd1, 1'b0, '0, '0, '0, '0, '0));
    send_request(make_request(ret_pkg::MODE_ERASE, 16'(EFFECT_SLOTS - 1), 1'b0, '0, '0, '0,
                              '0, '0));
  endtask

  // hold the result side off for a long stretch while requests keep coming
  task automatic test_output_backpressure();
    idle_on  = 1'b0;
    hold_len = 400;
    repeat (24) send_request(random_request());
  endtask

  task automatic test_random_traffic(input int n_requests, input bit with_idle);
    idle_on = with_idle;
    repeat (n_requests) send_request(random_request());
  endtask

  // drive the result-side stall: a requested long hold, else random stalls
  initial begin : out_stall_gen
    int n;
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        n        = hold_len;
        hold_len = 0;
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        n = pick_gap();
        if (n != 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin : check_results
    outcome_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = pending_outcomes.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", status, want.status));
        if (rumble_active !== want.active)
          report_mismatch($sformatf("rumble_active got %0b want %0b", rumble_active,
                                    want.active));
      end
    end
  end

  initial begin : run_tests
    int waited;
    foreach (effects[s]) effects[s] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_upload_checks();
    test_play_and_ticks();
    test_output_backpressure();
    test_random_traffic(400, 1'b1);
    test_random_traffic(300, 1'b0);
    test_random_traffic(400, 1'b1);
    test_random_traffic(300, 1'b0);
    test_random_traffic(150, 1'b1);
    in_valid <= 1'b0;

    // wait for the last results, then let the sweep settle
    waited = 0;
    while (pending_outcomes.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_outcomes.size() != 0)
      report_mismatch($sformatf("%0d requests never answered", pending_outcomes.size()));

    if (errors == 0) begin
      $display("rumble_effect_table regression: pass");
    end else begin
      $display("rumble_effect_table regression: fail");
    end
    $finish;
  end

  // give up on a hung run
  initial begin : watchdog
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("rumble_effect_table regression: fail");
    $finish;
  end

endmodule
